// ===== design/ptr_pkg.sv =====
`timescale 1ns / 1ps
package ptr_pkg;

	// Replacement policies; the unused code behaves as FIFO.
	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;
	localparam logic [1:0] POL_SPARE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] CFG_FRAME_COUNT = 2'd1;
	localparam logic [1:0] CFG_POLICY      = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int OFFSET_W   = 5;
	localparam int FCOUNT_W   = 7;
	localparam int POLICY_W   = 2;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd12;
	localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 7'd64;
	localparam int OFFSET_MAX = 20;
	localparam int PA_W       = 26;
	localparam int TIME_W     = 32;
	localparam int PAGE_MAX_W = 32;

	localparam int MAX_FRAMES_DEF = 64;
	localparam int ADDR_BITS_DEF  = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan;
		logic clock_step;
		logic commit;
	} ptr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic need_clock;
		logic clock_found;
		logic out_free;
	} ptr_sts_t;

endpackage

// ===== design/ptr_ram.sv =====
`timescale 1ns / 1ps
module ptr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/ptr_ctrl.sv =====
`timescale 1ns / 1ps
module ptr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptr_pkg::ptr_sts_t sts,
	output ptr_pkg::ptr_cmd_t cmd
);
	import ptr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_CLOCK  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.need_clock ? ST_CLOCK : ST_COMMIT;
				end
			end
			ST_CLOCK: begin
				cmd.clock_step = 1'b1;
				if (sts.clock_found) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free) else $error("commit with output busy");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_SCAN) else $error("accept did not start a scan");
	a_clock_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_done && sts.need_clock) |=> cmd.clock_step)
		else $error("clock sweep not started");
endmodule

// ===== design/ptr_datapath.sv =====
`timescale 1ns / 1ps
module ptr_datapath #(
	parameter int MAX_FRAMES = ptr_pkg::MAX_FRAMES_DEF,
	parameter int ADDR_BITS  = ptr_pkg::ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptr_pkg::ptr_cmd_t              cmd,
	output ptr_pkg::ptr_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [ptr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [ADDR_BITS-1:0]           logical_address,
	input  logic                           write_flag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ptr_pkg::PA_W-1:0]       physical_address,
	output logic                           hit,
	output logic                           evicted,
	output logic                           dirty_evicted
);
	import ptr_pkg::*;

	localparam int IDXW  = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
	localparam int CNTW  = $clog2(MAX_FRAMES + 1) > 0 ? $clog2(MAX_FRAMES + 1) : 1;
	localparam int PAGEW = ADDR_BITS > PAGE_MAX_W ? PAGE_MAX_W : ADDR_BITS;
	localparam int XW    = ADDR_BITS > OFFSET_MAX ? ADDR_BITS : OFFSET_MAX;

	// Configuration registers
	logic [OFFSET_W-1:0] cfg_offset_q;
	logic [FCOUNT_W-1:0] cfg_frames_q;
	logic [POLICY_W-1:0] cfg_policy_q;

	// Per-item registers
	logic [PAGEW-1:0]      page_q;
	logic [OFFSET_MAX-1:0] offset_q;
	logic [OFFSET_W-1:0]   ob_q;
	logic [CNTW-1:0]       n_q;
	logic                  wr_q;
	logic [POLICY_W-1:0]   policy_q;

	// Frame state
	logic [MAX_FRAMES-1:0] valid_q, dirty_q, ref_q;
	logic [TIME_W-1:0]     access_time_q;
	logic [IDXW-1:0]       fifo_ptr_q, clock_hand_q, hand_q;

	// Scan state
	logic [CNTW-1:0]   scan_q;
	logic              rd_vld_s1;
	logic [IDXW-1:0]   rd_idx_s1;
	logic              hit_q, free_q;
	logic [IDXW-1:0]   hit_idx_q, free_idx_q, lru_idx_q;
	logic [TIME_W-1:0] lru_min_q;

	logic              out_valid_q;

	// Combinational
	logic [CNTW-1:0]   n_next;
	logic [OFFSET_W-1:0] ob_next;
	logic [XW-1:0]     addr_ext;
	logic [PAGEW-1:0]  page_rd;
	logic [TIME_W-1:0] lu_rd;
	logic              match_now, free_now;
	logic [IDXW-1:0]   fifo_p, frame_sel;
	logic              evict_sel;
	logic [IDXW-1:0]   rd_addr;

	always_comb begin
		if (cfg_frames_q == '0) begin
			n_next = CNTW'(1);
		end else if (32'(cfg_frames_q) > 32'(MAX_FRAMES)) begin
			n_next = CNTW'(MAX_FRAMES);
		end else begin
			n_next = CNTW'(cfg_frames_q);
		end
		ob_next  = (32'(cfg_offset_q) > 32'(OFFSET_MAX)) ? OFFSET_W'(OFFSET_MAX) : cfg_offset_q;
		addr_ext = XW'(logical_address);
		rd_addr  = scan_q[IDXW-1:0];
	end

	ptr_ram #(.WIDTH(PAGEW), .DEPTH(MAX_FRAMES)) u_page_ram (
		.clk   (clk),
		.we    (cmd.commit && !hit_q),
		.waddr (frame_sel),
		.wdata (page_q),
		.raddr (rd_addr),
		.rdata (page_rd)
	);

	ptr_ram #(.WIDTH(TIME_W), .DEPTH(MAX_FRAMES)) u_use_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (frame_sel),
		.wdata (access_time_q),
		.raddr (rd_addr),
		.rdata (lu_rd)
	);

	always_comb begin
		match_now = rd_vld_s1 && valid_q[rd_idx_s1] && (page_rd == page_q);
		free_now  = rd_vld_s1 && !valid_q[rd_idx_s1];
		sts.scan_done   = rd_vld_s1 && (CNTW'(rd_idx_s1) + CNTW'(1) == n_q);
		sts.need_clock  = (policy_q == POL_CLOCK) && !hit_q && !match_now
		                  && !free_q && !free_now;
		sts.clock_found = !ref_q[hand_q];
		sts.out_free    = !out_valid_q || out_ready;

		fifo_p    = (CNTW'(fifo_ptr_q) < n_q) ? fifo_ptr_q : '0;
		evict_sel = !hit_q && !free_q;
		if (hit_q) begin
			frame_sel = hit_idx_q;
		end else if (free_q) begin
			frame_sel = free_idx_q;
		end else if (policy_q == POL_LRU) begin
			frame_sel = lru_idx_q;
		end else if (policy_q == POL_CLOCK) begin
			frame_sel = hand_q;
		end else begin
			frame_sel = fifo_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_offset_q  <= OFFSET_RESET;
			cfg_frames_q  <= FCOUNT_RESET;
			cfg_policy_q  <= POL_FIFO;
			valid_q       <= '0;
			dirty_q       <= '0;
			ref_q         <= '0;
			access_time_q <= '0;
			fifo_ptr_q    <= '0;
			clock_hand_q  <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OFFSET_BITS: cfg_offset_q <= cfg_wdata[OFFSET_W-1:0];
					CFG_FRAME_COUNT: cfg_frames_q <= cfg_wdata[FCOUNT_W-1:0];
					CFG_POLICY:      cfg_policy_q <= cfg_wdata[POLICY_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept && access_time_q != '1) begin
				access_time_q <= access_time_q + TIME_W'(1);
			end
			rd_vld_s1 <= cmd.scan && (scan_q < n_q);
			if (cmd.clock_step && ref_q[hand_q]) begin
				ref_q[hand_q] <= 1'b0;
			end
			if (cmd.commit) begin
				valid_q[frame_sel] <= 1'b1;
				ref_q[frame_sel]   <= 1'b1;
				dirty_q[frame_sel] <= hit_q ? (dirty_q[frame_sel] | wr_q) : wr_q;
				if (evict_sel && policy_q == POL_CLOCK) begin
					clock_hand_q <= hand_q;
				end else if (evict_sel && policy_q != POL_LRU) begin
					fifo_ptr_q <= (CNTW'(fifo_p) + CNTW'(1) == n_q) ? '0 : fifo_p + IDXW'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and scan registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q   <= PAGEW'(addr_ext >> ob_next);
			offset_q <= addr_ext[OFFSET_MAX-1:0] & ~({OFFSET_MAX{1'b1}} << ob_next);
			ob_q     <= ob_next;
			n_q      <= n_next;
			wr_q     <= write_flag;
			policy_q <= cfg_policy_q;
			scan_q   <= '0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			hand_q   <= (CNTW'(clock_hand_q) < n_next) ? clock_hand_q : '0;
		end
		if (cmd.scan) begin
			if (scan_q < n_q) begin
				scan_q <= scan_q + CNTW'(1);
			end
			rd_idx_s1 <= rd_addr;
			if (match_now && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
			end
			if (free_now && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (rd_vld_s1 && (rd_idx_s1 == '0 || lu_rd < lru_min_q)) begin
				lru_min_q <= lu_rd;
				lru_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.clock_step && ref_q[hand_q]) begin
			hand_q <= (CNTW'(hand_q) + CNTW'(1) == n_q) ? '0 : hand_q + IDXW'(1);
		end
		if (cmd.commit) begin
			physical_address <= (PA_W'(frame_sel) << ob_q) | PA_W'(offset_q);
			hit              <= hit_q;
			evicted          <= evict_sel;
			dirty_evicted    <= evict_sel && dirty_q[frame_sel];
		end
	end

	assign out_valid = out_valid_q;

	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(access_time_q) <= access_time_q) else $error("access timer went back");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit_q) |=> (!evicted && !dirty_evicted))
		else $error("hit reported an eviction");
	a_dirty_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dirty_evicted) |-> evicted) else $error("dirty flag without eviction");
	a_commit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (valid_q[$past(frame_sel)] && ref_q[$past(frame_sel)]))
		else $error("committed frame not marked");
endmodule

// ===== design/page_translate_replace_top.sv =====
`timescale 1ns / 1ps
// Page translation with replacement through an inverted frame table.
//
// Input channel s_*: one beat per access, carrying the logical address in
// s_tdata and the write flag in s_tuser. Output channel m_*: exactly one beat
// per access, carrying the physical address and the hit, eviction and
// dirty-eviction flags. Configuration: cfg_we writes cfg_wdata into register
// cfg_index (0 offset bits, 1 frame count, 2 policy) at the clock edge; write
// only while idle.
//
// One access is handled at a time. A scan reads the frame table RAMs one
// frame per cycle over the n frames in use, and a new access is taken only
// once the last one has committed its result. A clock-policy eviction then
// sweeps the hand, clearing the reference bit of each frame it passes, until
// it stops on a frame whose reference bit is clear.
// The result sits in an output register, so the next access is accepted while
// it waits. If the receiver stalls, the following access finishes its scan
// and then holds until the pending result beat is taken.
// Reset clears all frames to free, the timer, the FIFO pointer and the clock
// hand, and loads the configuration defaults (12, 64, FIFO).
module page_translate_replace_top #(
	parameter int MAX_FRAMES = ptr_pkg::MAX_FRAMES_DEF,
	parameter int ADDR_BITS  = ptr_pkg::ADDR_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// logical_address, zero padding
	input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// write flag
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// physical_address, hit, evicted, dirty_evicted, zero padding
	output logic [((ptr_pkg::PA_W + 3 + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                                   cfg_we,
	input  logic [ptr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ptr_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import ptr_pkg::*;

	localparam int M_W = ((PA_W + 3 + 7) / 8) * 8;

	ptr_cmd_t        cmd;
	ptr_sts_t        sts;
	logic [PA_W-1:0] pa;
	logic            hit_b, ev_b, dev_b;

	ptr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptr_datapath #(.MAX_FRAMES(MAX_FRAMES), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.logical_address  (s_tdata[ADDR_BITS-1:0]),
		.write_flag       (s_tuser),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.physical_address (pa),
		.hit              (hit_b),
		.evicted          (ev_b),
		.dirty_evicted    (dev_b)
	);

	assign m_tdata = M_W'({dev_b, ev_b, hit_b, pa});
endmodule
